// File: src/ffa_pkg.sv
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the first-fit block allocator
// Holds the table entry layout, the opcode and status codes and the
// register map of the configuration port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffa_pkg;

   // Field widths fixed by the request and response words
   localparam int ADDR_W   = 20;
   localparam int TOP_W    = 21;
   localparam int NEED_W   = 22;
   localparam int CSR_ADDR_W = 3;

   // Heap span; a larger limit acts as this value
   localparam logic [TOP_W-1:0] HEAP_SPAN = 21'h100000;

   // Opcodes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;
   localparam logic [1:0] OP_RSVD    = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_NOMEM    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN  = 2'd3;

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] REG_HEAP_LIMIT = 3'd0;

   // One block table entry
   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] size;
      logic              free;
   } entry_type;

endpackage

// File: src/first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator over a block table
// Allocate, free and reallocate against an address-ordered table of blocks
// kept in one RAM; a scan reads one entry per cycle.
// ---------------------------------------------------------------------------
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-------------------
//   request  | req_opcode, req_request_bytes,         | req_valid/req_ready
//            | req_block_address                      |
//   response | rsp_status, rsp_result_address,        | rsp_valid/rsp_ready
//            | rsp_copy_bytes                         |
//   config   | psel, penable, pwrite, paddr, pwdata,  | APB, pready high
//            | prdata                                 |
//
// One word is worked on at a time. A table scan walks the N current blocks
// through the one-entry-per-cycle RAM read port; a moving reallocate runs two
// scans. Reset clears the count and heap top and sets the limit to the full
// span; the table needs no clearing pass. A finished response waits in its
// register while the next word is taken; the result is held back only if that
// register is still full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [ffa_pkg::ADDR_W-1:0]        req_request_bytes,
   input  logic [ffa_pkg::ADDR_W-1:0]        req_block_address,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [ffa_pkg::ADDR_W-1:0]        rsp_result_address,
   output logic [ffa_pkg::ADDR_W-1:0]        rsp_copy_bytes,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = ffa_pkg::ADDR_W;
   localparam int TW = ffa_pkg::TOP_W;
   localparam int NW = ffa_pkg::NEED_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_ALLOC,
      S_FREE,
      S_DONE
   } state_type;

   // Registers and next values
   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [AW-1:0]     reqb_ff, reqb_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic [IW-1:0]     fidx_ff, fidx_in;
   logic [AW-1:0]     foff_ff, foff_in;
   logic [AW-1:0]     fsize_ff, fsize_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [TW-1:0]     top_ff, top_in;
   logic [TW-1:0]     limit_ff, limit_in;
   logic [1:0]        st_ff, st_in;
   logic [AW-1:0]     res_ff, res_in;
   logic [AW-1:0]     copy_ff, copy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [AW-1:0]     rsp_res_ff, rsp_res_in;
   logic [AW-1:0]     rsp_copy_ff, rsp_copy_in;

   // RAM port signals
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   ffa_pkg::entry_type      wr_entry;
   logic [$bits(ffa_pkg::entry_type)-1:0] rd_raw;
   ffa_pkg::entry_type      rd_entry;

   // Datapath helpers
   logic              req_accept;
   logic              csr_write;
   logic              find_hit;
   logic              fit_hit;
   logic              scan_end;
   logic              room;
   logic              last_blk;
   logic [TW-1:0]     eff_limit;
   logic [NW-1:0]     need;
   logic [TW-1:0]     hdr;

   assign hdr        = TW'(HEADER_BYTES);
   assign rd_entry   = ffa_pkg::entry_type'(rd_raw);
   assign req_accept = req_valid && req_ready;
   assign csr_write  = psel && penable && pwrite;

   // Match tests on the word read in the previous cycle
   assign find_hit  = pend_ff && (({1'b0, rd_entry.offset} + hdr) == {1'b0, addr_ff});
   assign fit_hit   = pend_ff && rd_entry.free && (rd_entry.size >= reqb_ff);
   assign scan_end  = (scan_ff >= count_ff);

   // Append check against the clamped limit
   assign eff_limit = (limit_ff > ffa_pkg::HEAP_SPAN) ? ffa_pkg::HEAP_SPAN : limit_ff;
   assign need      = NW'(top_ff) + NW'(HEADER_BYTES) + NW'(reqb_ff);
   assign room      = (count_ff < CW'(MAX_BLOCKS)) && (need <= NW'(eff_limit));
   assign last_blk  = ((CW'(fidx_ff) + CW'(1)) == count_ff);

   // Block table
   ffa_ram #(
      .WIDTH ($bits(ffa_pkg::entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (rd_raw)
   );

   // Next-state and datapath logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      reqb_in       = reqb_ff;
      addr_in       = addr_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      fidx_in       = fidx_ff;
      foff_in       = foff_ff;
      fsize_in      = fsize_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      limit_in      = limit_ff;
      st_in         = st_ff;
      res_in        = res_ff;
      copy_in       = copy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_copy_in   = rsp_copy_ff;
      wr_en         = 1'b0;
      wr_addr       = fidx_ff;
      wr_entry      = '{offset: foff_ff, size: fsize_ff, free: 1'b1};

      // Configuration write
      if (csr_write && (paddr == ffa_pkg::REG_HEAP_LIMIT)) begin
         limit_in = pwdata[TW-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in   = req_opcode;
               reqb_in = req_request_bytes;
               addr_in = req_block_address;
               st_in   = ffa_pkg::ST_OK;
               res_in  = '0;
               copy_in = '0;
               scan_in = '0;
               case (req_opcode) inside
                  ffa_pkg::OP_ALLOC, ffa_pkg::OP_REALLOC: begin
                     if (req_request_bytes == '0) begin
                        st_in    = ffa_pkg::ST_ZERO;
                        state_in = S_DONE;
                     end else if ((req_opcode == ffa_pkg::OP_REALLOC) &&
                                  (req_block_address != '0)) begin
                        state_in = S_FIND;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  ffa_pkg::OP_FREE: begin
                     if (req_block_address == '0) begin
                        st_in    = ffa_pkg::ST_ZERO;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                     st_in    = ffa_pkg::ST_ZERO;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Search the table for the block with this data address
         S_FIND: begin
            if (find_hit) begin
               fidx_in  = pidx_ff;
               foff_in  = rd_entry.offset;
               fsize_in = rd_entry.size;
               if (op_ff == ffa_pkg::OP_FREE) begin
                  state_in = S_FREE;
               end else if (rd_entry.size >= reqb_ff) begin
                  res_in   = addr_ff;
                  state_in = S_DONE;
               end else begin
                  scan_in  = '0;
                  state_in = S_ALLOC;
               end
            end else if (scan_end) begin
               st_in    = ffa_pkg::ST_UNKNOWN;
               state_in = S_DONE;
            end else begin
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         // Search for the first free block that fits, else append
         S_ALLOC: begin
            if (fit_hit) begin
               wr_en    = 1'b1;
               wr_addr  = pidx_ff;
               wr_entry = '{offset: rd_entry.offset, size: rd_entry.size, free: 1'b0};
               res_in   = AW'({1'b0, rd_entry.offset} + hdr);
               if (op_ff == ffa_pkg::OP_REALLOC && addr_ff != '0) begin
                  copy_in  = fsize_ff;
                  state_in = S_FREE;
               end else begin
                  state_in = S_DONE;
               end
            end else if (scan_end) begin
               if (room) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IW-1:0];
                  wr_entry = '{offset: top_ff[AW-1:0], size: reqb_ff, free: 1'b0};
                  res_in   = AW'(top_ff + hdr);
                  top_in   = TW'(need);
                  count_in = count_ff + CW'(1);
                  if (op_ff == ffa_pkg::OP_REALLOC && addr_ff != '0) begin
                     copy_in  = fsize_ff;
                     state_in = S_FREE;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  st_in    = ffa_pkg::ST_NOMEM;
                  state_in = S_DONE;
               end
            end else begin
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         // Drop the last block or mark an inner block free
         S_FREE: begin
            if (last_blk) begin
               top_in   = {1'b0, foff_ff};
               count_in = count_ff - CW'(1);
            end else begin
               wr_en = 1'b1;
            end
            state_in = S_DONE;
         end

         // Hand the result to the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_res_in    = (st_ff == ffa_pkg::ST_OK) ? res_ff : '0;
               rsp_copy_in   = (st_ff == ffa_pkg::ST_OK) ? copy_ff : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= ffa_pkg::HEAP_SPAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      reqb_ff       <= reqb_in;
      addr_ff       <= addr_in;
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      fidx_ff       <= fidx_in;
      foff_ff       <= foff_in;
      fsize_ff      <= fsize_in;
      st_ff         <= st_in;
      res_ff        <= res_in;
      copy_ff       <= copy_in;
      rsp_status_ff <= rsp_status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_copy_ff   <= rsp_copy_in;
   end

   // Ports
   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_res_ff;
   assign rsp_copy_bytes     = rsp_copy_ff;
   assign pready             = 1'b1;
   assign prdata             = (paddr == ffa_pkg::REG_HEAP_LIMIT) ?
                               {{(32-TW){1'b0}}, limit_ff} : '0;

   // Assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("block count exceeds table size");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (top_ff == '0))
      else $error("empty table with nonzero heap top");

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= ffa_pkg::HEAP_SPAN)
      else $error("heap top beyond heap span");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CW'(1)) ||
          (count_ff + CW'(1) == $past(count_ff))))
      else $error("block count moved by more than one");

endmodule

// File: src/ffa_ram.sv
// ---------------------------------------------------------------------------
// ffa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_ram #(
   parameter int WIDTH = 41,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
